@@ rtl/core/tsiu_pkg.sv @@
// Shared types, codes and constants of the Thumb store-immediate unit.
package tsiu_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OFFSET_W  = 12;

  localparam logic [REG_IDX_W-1:0] REG_SP = 4'd13;
  localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  typedef enum logic [3:0] {
    OP_STR_T1    = 4'd0,
    OP_STRB_T1   = 4'd1,
    OP_STRB_T2   = 4'd2,
    OP_STRB_T3   = 4'd3,
    OP_STRH_T1   = 4'd4,
    OP_STRH_T2   = 4'd5,
    OP_STRH_T3   = 4'd6,
    OP_STR_T2    = 4'd7,
    OP_STR_T3    = 4'd8,
    OP_STR_T4    = 4'd9,
    OP_REG_WRITE = 4'd10
  } op_t;

  // Decoded instruction as held in the input register.
  typedef struct packed {
    logic                 is_store;
    logic                 is_regwr;
    logic [REG_IDX_W-1:0] rn;
    logic [REG_IDX_W-1:0] rt;
    logic [OFFSET_W-1:0]  offset;
    logic [2:0]           size;
    logic                 pc_inc4;
    logic                 sub_off;
    logic                 use_base;
    logic                 wback;
    logic                 fault;
  } dec_t;

  typedef struct packed {
    logic              store_enable;
    logic [DATA_W-1:0] store_address;
    logic [DATA_W-1:0] store_data;
    logic [2:0]        store_size;
    logic              usage_fault;
    logic              advance_it;
  } res_t;

  // Register-file updates produced by one executed item.
  typedef struct packed {
    logic                 ram_we;
    logic [REG_IDX_W-1:0] ram_addr;
    logic [DATA_W-1:0]    ram_data;
    logic                 pc_we;
    logic [DATA_W-1:0]    pc_data;
  } wb_t;

endpackage

@@ rtl/core/tsiu_if.sv @@
// Valid/ready channel interfaces for instruction items and store results.
interface tsiu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] instruction;
  logic        in_it_block;
  logic        condition_passed;
  logic [3:0]  reg_index;
  logic [31:0] reg_value;

  modport source (output valid, operation, instruction, in_it_block, condition_passed,
                  reg_index, reg_value, input ready);
  modport sink (input valid, operation, instruction, in_it_block, condition_passed,
                reg_index, reg_value, output ready);
endinterface

interface tsiu_out_if;
  logic        valid;
  logic        ready;
  logic        store_enable;
  logic [31:0] store_address;
  logic [31:0] store_data;
  logic [2:0]  store_size;
  logic        usage_fault;
  logic        advance_it;

  modport source (output valid, store_enable, store_address, store_data, store_size,
                  usage_fault, advance_it, input ready);
  modport sink (input valid, store_enable, store_address, store_data, store_size,
                usage_fault, advance_it, output ready);
endinterface

@@ rtl/core/tsiu_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module tsiu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/tsiu_decode.sv @@
// Instruction decoder: register fields, scaled immediate and fault checks.
module tsiu_decode (
  input  logic [3:0]      operation,
  input  logic [31:0]     instruction,
  output tsiu_pkg::dec_t  dec
);

  tsiu_pkg::op_t op;
  logic p_bit, u_bit, w_bit;

  assign op    = tsiu_pkg::op_t'(operation);
  assign p_bit = instruction[10];
  assign u_bit = instruction[9];
  assign w_bit = instruction[8];

  always_comb begin
    dec          = '0;
    dec.pc_inc4  = 1'b1;
    unique case (op)
      tsiu_pkg::OP_STR_T1, tsiu_pkg::OP_STRB_T1, tsiu_pkg::OP_STRH_T1: begin
        dec.is_store = 1'b1;
        dec.rn       = {1'b0, instruction[21:19]};
        dec.rt       = {1'b0, instruction[18:16]};
        dec.pc_inc4  = 1'b0;
        if (op == tsiu_pkg::OP_STR_T1) begin
          dec.size   = tsiu_pkg::SIZE_WORD;
          dec.offset = {5'd0, instruction[26:22], 2'b00};
        end else if (op == tsiu_pkg::OP_STRH_T1) begin
          dec.size   = tsiu_pkg::SIZE_HALF;
          dec.offset = {6'd0, instruction[26:22], 1'b0};
        end else begin
          dec.size   = tsiu_pkg::SIZE_BYTE;
          dec.offset = {7'd0, instruction[26:22]};
        end
      end
      tsiu_pkg::OP_STR_T2: begin
        dec.is_store = 1'b1;
        dec.rn       = tsiu_pkg::REG_SP;
        dec.rt       = {1'b0, instruction[26:24]};
        dec.offset   = {2'd0, instruction[23:16], 2'b00};
        dec.size     = tsiu_pkg::SIZE_WORD;
        dec.pc_inc4  = 1'b0;
      end
      tsiu_pkg::OP_STRB_T2, tsiu_pkg::OP_STRH_T2, tsiu_pkg::OP_STR_T3: begin
        dec.is_store = 1'b1;
        dec.rn       = instruction[19:16];
        dec.rt       = instruction[15:12];
        dec.offset   = instruction[11:0];
        dec.size     = (op == tsiu_pkg::OP_STRB_T2) ? tsiu_pkg::SIZE_BYTE :
                       (op == tsiu_pkg::OP_STRH_T2) ? tsiu_pkg::SIZE_HALF :
                                                      tsiu_pkg::SIZE_WORD;
        dec.fault    = (instruction[19:16] == tsiu_pkg::REG_PC) ||
                       ((op == tsiu_pkg::OP_STRB_T2) &&
                        (instruction[15:12] == tsiu_pkg::REG_PC));
      end
      tsiu_pkg::OP_STRB_T3, tsiu_pkg::OP_STRH_T3, tsiu_pkg::OP_STR_T4: begin
        dec.is_store = 1'b1;
        dec.rn       = instruction[19:16];
        dec.rt       = instruction[15:12];
        dec.offset   = {4'd0, instruction[7:0]};
        dec.size     = (op == tsiu_pkg::OP_STRB_T3) ? tsiu_pkg::SIZE_BYTE :
                       (op == tsiu_pkg::OP_STRH_T3) ? tsiu_pkg::SIZE_HALF :
                                                      tsiu_pkg::SIZE_WORD;
        dec.sub_off  = !u_bit;
        dec.use_base = !p_bit;
        dec.wback    = w_bit;
        dec.fault    = (instruction[19:16] == tsiu_pkg::REG_PC) || (!p_bit && !w_bit);
      end
      tsiu_pkg::OP_REG_WRITE: begin
        dec.is_regwr = 1'b1;
      end
      default: begin
        // Unused operation codes do nothing.
        dec = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/tsiu_exec.sv @@
// Execute logic: address generation, store request and register updates.
module tsiu_exec (
  input  tsiu_pkg::dec_t      dec,
  input  logic                in_it_block,
  input  logic                condition_passed,
  input  logic [3:0]          reg_index,
  input  logic [31:0]         reg_value,
  input  logic [31:0]         pc,
  input  logic [31:0]         base,
  input  logic [31:0]         src,
  output tsiu_pkg::res_t      res,
  output tsiu_pkg::wb_t       wb
);

  logic        execute;
  logic        do_store;
  logic [31:0] offset_ext;
  logic [31:0] target;
  logic [31:0] addr;

  assign execute    = dec.is_store && !dec.fault;
  assign do_store   = execute && (!in_it_block || condition_passed);
  assign offset_ext = {20'd0, dec.offset};
  assign target     = dec.sub_off ? (base - offset_ext) : (base + offset_ext);
  assign addr       = dec.use_base ? base : target;

  always_comb begin
    res               = '0;
    res.usage_fault   = dec.is_store && dec.fault;
    res.advance_it    = execute && in_it_block;
    if (do_store) begin
      res.store_enable  = 1'b1;
      res.store_address = addr;
      res.store_data    = src;
      res.store_size    = dec.size;
    end
  end

  always_comb begin
    wb = '0;
    if (dec.is_regwr) begin
      if (reg_index == tsiu_pkg::REG_PC) begin
        wb.pc_we   = 1'b1;
        wb.pc_data = reg_value;
      end else begin
        wb.ram_we   = 1'b1;
        wb.ram_addr = reg_index;
        wb.ram_data = reg_value;
      end
    end else if (execute) begin
      wb.pc_we   = 1'b1;
      wb.pc_data = pc + (dec.pc_inc4 ? 32'd4 : 32'd2);
      // An encoding that executes never has Rn equal to PC, so writeback lands in the RAM.
      if (do_store && dec.wback && (dec.rn != tsiu_pkg::REG_PC)) begin
        wb.ram_we   = 1'b1;
        wb.ram_addr = dec.rn;
        wb.ram_data = target;
      end
    end
  end

endmodule

@@ rtl/core/thumb_store_immediate_unit.sv @@
// Top level of the Thumb store-immediate unit.
// The unit takes one instruction item per cycle unless the result channel stalls it, and
// returns one result item for each: the item is decoded into an input register, then the
// address add, the register-file update and the result register all complete together as
// the item leaves that register. Registers 0 to 14 live in a small two-read-port RAM with
// per-entry valid bits that make every entry read as zero after reset; PC is a separate
// register. A write made in the cycle that a following item is read is forwarded, so
// dependent items run back to back. The only stalls come from the result channel: while a
// result waits to be taken, one more item can still be taken into the input register.
module thumb_store_immediate_unit (
  input logic         clk,
  input logic         rst_n,
  tsiu_in_if.sink     in_ch,
  tsiu_out_if.source  out_ch
);

  // Input register stage.
  logic                 ex_v_r;
  tsiu_pkg::dec_t       ex_dec_r;
  logic                 ex_it_r;
  logic                 ex_cond_r;
  logic [3:0]           ex_idx_r;
  logic [31:0]          ex_val_r;

  logic                 out_v_r;
  tsiu_pkg::res_t       out_res_r;

  logic [31:0]          pc_r;
  logic [14:0]          valid_r;

  logic                 out_free;
  logic                 stage_load;
  logic                 exec_fire;

  tsiu_pkg::dec_t       in_dec;
  tsiu_pkg::res_t       ex_res;
  tsiu_pkg::wb_t        ex_wb;

  logic [3:0]           raddr_a;
  logic [3:0]           raddr_b;
  logic [31:0]          rdata_a;
  logic [31:0]          rdata_b;
  logic                 fwd_a_r, fwd_b_r;
  logic [31:0]          fwd_data_r;
  logic                 rvld_a_r, rvld_b_r;
  logic [31:0]          base;
  logic [31:0]          src;

  assign out_free   = !out_v_r || out_ch.ready;
  assign stage_load = !ex_v_r || out_free;
  assign exec_fire  = ex_v_r && out_free;
  assign in_ch.ready = stage_load;

  tsiu_decode u_decode (
    .operation   (in_ch.operation),
    .instruction (in_ch.instruction),
    .dec         (in_dec)
  );

  // Read the registers of the item entering the stage, or keep reading the held one.
  assign raddr_a = stage_load ? in_dec.rn : ex_dec_r.rn;
  assign raddr_b = stage_load ? in_dec.rt : ex_dec_r.rt;

  tsiu_ram #(
    .WIDTH (32),
    .DEPTH (tsiu_pkg::REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (exec_fire && ex_wb.ram_we),
    .waddr   (ex_wb.ram_addr),
    .wdata   (ex_wb.ram_data),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_comb begin
    if (ex_dec_r.rn == tsiu_pkg::REG_PC) begin
      base = pc_r;
    end else if (fwd_a_r) begin
      base = fwd_data_r;
    end else begin
      base = rvld_a_r ? rdata_a : 32'd0;
    end
    if (ex_dec_r.rt == tsiu_pkg::REG_PC) begin
      src = pc_r;
    end else if (fwd_b_r) begin
      src = fwd_data_r;
    end else begin
      src = rvld_b_r ? rdata_b : 32'd0;
    end
  end

  tsiu_exec u_exec (
    .dec              (ex_dec_r),
    .in_it_block      (ex_it_r),
    .condition_passed (ex_cond_r),
    .reg_index        (ex_idx_r),
    .reg_value        (ex_val_r),
    .pc               (pc_r),
    .base             (base),
    .src              (src),
    .res              (ex_res),
    .wb               (ex_wb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= '0;
      valid_r <= '0;
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      if (stage_load) begin
        ex_v_r <= in_ch.valid;
      end
      if (out_free) begin
        out_v_r <= exec_fire;
      end
      if (exec_fire && ex_wb.pc_we) begin
        pc_r <= ex_wb.pc_data;
      end
      if (exec_fire && ex_wb.ram_we) begin
        valid_r[ex_wb.ram_addr] <= 1'b1;
      end
      // The RAM returns the old contents when read and written at the same edge.
      fwd_a_r <= exec_fire && ex_wb.ram_we && (ex_wb.ram_addr == raddr_a);
      fwd_b_r <= exec_fire && ex_wb.ram_we && (ex_wb.ram_addr == raddr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load && in_ch.valid) begin
      ex_dec_r  <= in_dec;
      ex_it_r   <= in_ch.in_it_block;
      ex_cond_r <= in_ch.condition_passed;
      ex_idx_r  <= in_ch.reg_index;
      ex_val_r  <= in_ch.reg_value;
    end
    if (exec_fire) begin
      out_res_r <= ex_res;
    end
    fwd_data_r <= ex_wb.ram_data;
    rvld_a_r   <= (raddr_a != tsiu_pkg::REG_PC) && valid_r[raddr_a[3:0] == tsiu_pkg::REG_PC ?
                  4'd0 : raddr_a];
    rvld_b_r   <= (raddr_b != tsiu_pkg::REG_PC) && valid_r[raddr_b[3:0] == tsiu_pkg::REG_PC ?
                  4'd0 : raddr_b];
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.store_enable  = out_res_r.store_enable;
  assign out_ch.store_address = out_res_r.store_address;
  assign out_ch.store_data    = out_res_r.store_data;
  assign out_ch.store_size    = out_res_r.store_size;
  assign out_ch.usage_fault   = out_res_r.usage_fault;
  assign out_ch.advance_it    = out_res_r.advance_it;

  // A faulting item leaves PC untouched.
  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && ex_res.usage_fault) |=> (pc_r == $past(pc_r)))
    else $error("PC changed on a usage fault");

  // A held item stays in the input register until the result side frees up.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_v_r && !out_free) |=> (ex_v_r && $stable(ex_dec_r)))
    else $error("stalled item lost from the input register");

  // PC is never written through the RAM port.
  a_no_ram_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && ex_wb.ram_we) |-> (ex_wb.ram_addr != tsiu_pkg::REG_PC))
    else $error("RAM write aimed at PC");

  // A store result always carries a size and never a fault.
  a_store_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.store_enable) |->
      ((out_res_r.store_size != tsiu_pkg::SIZE_NONE) && !out_res_r.usage_fault))
    else $error("store result with no size or with a fault");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the Thumb store-immediate unit: directed and random instructions.
`timescale 1ns / 100ps

module tb_top;
  import tsiu_pkg::*;

  localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] insn;
    logic        in_it;
    logic        cond_ok;
    logic [3:0]  reg_idx;
    logic [31:0] reg_val;
  } instr_item_t;

  logic clk;
  logic rst_n;

  tsiu_in_if  in_ch ();
  tsiu_out_if out_ch ();

  thumb_store_immediate_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  instr_item_t pending_items[$];
  res_t        expected_results[$];
  instr_item_t cur_item;
  logic [31:0] reg_file [REG_COUNT];

  int unsigned n_queued;
  int unsigned n_sent;
  int unsigned n_received;
  int unsigned n_errors;
  int unsigned n_cycles;
  int unsigned n_stores;
  int unsigned n_skipped;
  int unsigned n_faults;
  int unsigned n_reg_writes;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Works out the result of one instruction and applies its effect on the register file.
  function automatic res_t predict_store(instr_item_t it);
    logic [3:0]  rn;
    logic [3:0]  rt;
    logic [31:0] offs;
    logic [31:0] base;
    logic [31:0] target;
    logic [31:0] addr;
    logic [31:0] pc_step;
    logic [2:0]  sz;
    logic        indexed;
    logic        fault;
    logic        wback;
    res_t        r;
    r       = '0;
    rn      = '0;
    rt      = '0;
    offs    = '0;
    sz      = SIZE_NONE;
    pc_step = 32'd4;
    indexed = 1'b0;
    fault   = 1'b0;
    wback   = 1'b0;
    case (it.op)
      OP_STR_T1, OP_STRB_T1, OP_STRH_T1: begin
        rn = {1'b0, it.insn[21:19]};
        rt = {1'b0, it.insn[18:16]};
        sz = (it.op == OP_STR_T1) ? SIZE_WORD : (it.op == OP_STRH_T1) ? SIZE_HALF : SIZE_BYTE;
        offs = 32'(it.insn[26:22]) * 32'(sz);
        pc_step = 32'd2;
      end
      OP_STR_T2: begin
        rn = REG_SP;
        rt = {1'b0, it.insn[26:24]};
        offs = 32'(it.insn[23:16]) << 2;
        sz = SIZE_WORD;
        pc_step = 32'd2;
      end
      OP_STRB_T2, OP_STRH_T2, OP_STR_T3: begin
        rn = it.insn[19:16];
        rt = it.insn[15:12];
        offs = 32'(it.insn[11:0]);
        sz = (it.op == OP_STRB_T2) ? SIZE_BYTE : (it.op == OP_STRH_T2) ? SIZE_HALF : SIZE_WORD;
        fault = (rn == REG_PC) || (it.op == OP_STRB_T2 && rt == REG_PC);
      end
      OP_STRB_T3, OP_STRH_T3, OP_STR_T4: begin
        rn = it.insn[19:16];
        rt = it.insn[15:12];
        offs = 32'(it.insn[7:0]);
        sz = (it.op == OP_STRB_T3) ? SIZE_BYTE : (it.op == OP_STRH_T3) ? SIZE_HALF : SIZE_WORD;
        indexed = 1'b1;
        fault = (rn == REG_PC) || (!it.insn[10] && !it.insn[8]);
      end
      OP_REG_WRITE: begin
        reg_file[it.reg_idx] = it.reg_val;
        n_reg_writes++;
        return r;
      end
      default: begin
        return r;
      end
    endcase

    if (fault) begin
      r.usage_fault = 1'b1;
      n_faults++;
      return r;
    end

    base   = reg_file[rn];
    target = base + offs;
    addr   = target;
    if (indexed) begin
      target = it.insn[9] ? base + offs : base - offs;
      wback  = it.insn[8];
      addr   = it.insn[10] ? target : base;
    end

    if (!it.in_it || it.cond_ok) begin
      r.store_enable  = 1'b1;
      r.store_address = addr;
      r.store_data    = reg_file[rt];
      r.store_size    = sz;
      // The source value is taken before the base is written back.
      if (wback) begin
        reg_file[rn] = target;
      end
      n_stores++;
    end else begin
      n_skipped++;
    end
    r.advance_it = it.in_it;
    reg_file[REG_PC] = reg_file[REG_PC] + pc_step;
    return r;
  endfunction

  function automatic logic [31:0] enc_imm5(logic [4:0] imm5, logic [2:0] rn, logic [2:0] rt);
    return {5'b0, imm5, rn, rt, 16'h0};
  endfunction

  function automatic logic [31:0] enc_sp_imm8(logic [2:0] rt, logic [7:0] imm8);
    return {5'b0, rt, imm8, 16'h0};
  endfunction

  function automatic logic [31:0] enc_imm12(logic [3:0] rn, logic [3:0] rt, logic [11:0] imm12);
    return {12'h0, rn, rt, imm12};
  endfunction

  function automatic logic [31:0] enc_puw(logic [3:0] rn, logic [3:0] rt, logic p, logic u,
                                          logic w, logic [7:0] imm8);
    return {12'h0, rn, rt, 1'b1, p, u, w, imm8};
  endfunction

  task automatic queue_item(instr_item_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic queue_store(op_t op, logic [31:0] insn, logic in_it, logic cond_ok);
    queue_item('{op: op, insn: insn, in_it: in_it, cond_ok: cond_ok, reg_idx: 4'd0,
                 reg_val: 32'd0});
  endtask

  task automatic queue_reg_write(logic [3:0] idx, logic [31:0] val);
    queue_item('{op: OP_REG_WRITE, insn: 32'd0, in_it: 1'b0, cond_ok: 1'b0, reg_idx: idx,
                 reg_val: val});
  endtask

  // Mostly well-formed stores with random content, some register writes to spread the
  // base values, and a little noise from unused operation codes.
  function automatic instr_item_t random_item();
    instr_item_t it;
    int unsigned pick;
    it.insn    = $urandom();
    it.in_it   = ($urandom_range(0, 99) < 30);
    it.cond_ok = 1'($urandom_range(0, 1));
    it.reg_idx = 4'($urandom_range(0, 15));
    it.reg_val = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else if (pick < 18) begin
      it.op = OP_REG_WRITE;
      case ($urandom_range(0, 3))
        0: it.reg_val = 32'($urandom_range(0, 255));
        1: it.reg_val = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        default: ;
      endcase
    end else begin
      it.op = 4'($urandom_range(OP_STR_T1, OP_STR_T4));
      // Keep most indexed forms away from the undefined P=0, W=0 encoding.
      if ((it.op == OP_STRB_T3 || it.op == OP_STRH_T3 || it.op == OP_STR_T4) &&
          !it.insn[10] && !it.insn[8] && $urandom_range(0, 99) < 80) begin
        it.insn[8] = 1'b1;
      end
    end
    return it;
  endfunction

  task automatic check_result_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Sender: presents queued instructions and records each transfer with the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_store(cur_item));
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 &&
            !((n_sent < 700 || n_sent >= 1000) && $urandom_range(0, 99) < IDLE_PCT)) begin
          cur_item = pending_items.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.operation        <= cur_item.op;
          in_ch.instruction      <= cur_item.insn;
          in_ch.in_it_block      <= cur_item.in_it;
          in_ch.condition_passed <= cur_item.cond_ok;
          in_ch.reg_index        <= cur_item.reg_idx;
          in_ch.reg_value        <= cur_item.reg_val;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the unit fills and back-pressures.
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && n_received >= 400) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !((n_received < 700 || n_received >= 1000) &&
                        $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: compares every result transfer with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_received++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual enable %0b address 0x%08h",
                 $time, out_ch.store_enable, out_ch.store_address);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_result_field("store_enable", want.store_enable, out_ch.store_enable);
        check_result_field("store_address", want.store_address, out_ch.store_address);
        check_result_field("store_data", want.store_data, out_ch.store_data);
        check_result_field("store_size", want.store_size, out_ch.store_size);
        check_result_field("usage_fault", want.usage_fault, out_ch.usage_fault);
        check_result_field("advance_it", want.advance_it, out_ch.advance_it);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", n_cycles,
               expected_results.size());
      $display("FAIL thumb_store_immediate_unit");
      $finish;
    end
  end

  initial begin
    int unsigned n_counted;
    instr_item_t it;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = '0;
    in_ch.instruction      = '0;
    in_ch.in_it_block      = 1'b0;
    in_ch.condition_passed = 1'b0;
    in_ch.reg_index        = '0;
    in_ch.reg_value        = '0;
    out_ch.ready           = 1'b0;
    hold_left              = 0;
    hold_done              = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) begin
      reg_file[i] = '0;
    end

    // Directed part: field extremes, every encoding, faults, indexing modes and IT skips.
    queue_reg_write(4'd0, 32'hFFFF_FFFF);
    queue_reg_write(4'd1, 32'h8000_0000);
    queue_reg_write(REG_SP, 32'h2000_1000);
    queue_reg_write(4'd2, 32'h1234_5678);
    queue_store(OP_STR_T1, enc_imm5(5'd31, 3'd1, 3'd2), 1'b0, 1'b0);
    queue_store(OP_STRB_T1, enc_imm5(5'd0, 3'd0, 3'd1), 1'b0, 1'b0);
    queue_store(OP_STRH_T1, enc_imm5(5'd31, 3'd0, 3'd2), 1'b0, 1'b0);
    queue_store(OP_STR_T2, enc_sp_imm8(3'd7, 8'hFF), 1'b0, 1'b0);
    queue_store(OP_STRB_T2, enc_imm12(4'd0, 4'd2, 12'hFFF), 1'b0, 1'b0);
    queue_store(OP_STRB_T2, enc_imm12(4'd1, REG_PC, 12'h000), 1'b0, 1'b0);
    queue_store(OP_STRH_T2, enc_imm12(REG_PC, 4'd0, 12'h010), 1'b0, 1'b0);
    queue_store(OP_STR_T3, enc_imm12(4'd1, REG_PC, 12'h004), 1'b0, 1'b0);
    queue_store(OP_STRB_T3, enc_puw(4'd1, 4'd2, 1'b1, 1'b1, 1'b0, 8'hFF), 1'b0, 1'b0);
    queue_store(OP_STRH_T3, enc_puw(4'd1, 4'd2, 1'b1, 1'b0, 1'b0, 8'h01), 1'b0, 1'b0);
    queue_store(OP_STR_T4, enc_puw(4'd2, 4'd0, 1'b1, 1'b1, 1'b1, 8'h10), 1'b0, 1'b0);
    queue_store(OP_STR_T4, enc_puw(4'd2, 4'd0, 1'b0, 1'b0, 1'b1, 8'hFF), 1'b0, 1'b0);
    queue_store(OP_STRB_T3, enc_puw(4'd2, 4'd0, 1'b0, 1'b1, 1'b0, 8'h00), 1'b0, 1'b0);
    queue_store(OP_STR_T4, enc_puw(REG_PC, 4'd0, 1'b1, 1'b1, 1'b1, 8'h00), 1'b0, 1'b0);
    queue_store(OP_STR_T4, enc_puw(4'd2, 4'd0, 1'b1, 1'b1, 1'b1, 8'h20), 1'b1, 1'b0);
    queue_store(OP_STR_T1, enc_imm5(5'd1, 3'd2, 3'd0), 1'b1, 1'b1);
    queue_reg_write(REG_PC, 32'hFFFF_FFFE);
    queue_store(OP_STR_T1, enc_imm5(5'd0, 3'd0, 3'd0), 1'b0, 1'b0);
    queue_item('{op: OP_LAST_UNUSED, insn: 32'hFFFF_FFFF, in_it: 1'b1, cond_ok: 1'b1,
                 reg_idx: 4'hF, reg_val: 32'hFFFF_FFFF});

    n_counted = 0;
    while (n_counted < RANDOM_ITEMS) begin
      it = random_item();
      queue_item(it);
      if (it.op < OP_FIRST_UNUSED) begin
        n_counted++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent != n_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Executed %0d stores, %0d skipped by a failed IT condition, %0d usage faults,",
             n_stores, n_skipped, n_faults);
    $display("  %0d register writes.", n_reg_writes);
    $display("Checked %0d results from %0d instructions, %0d mismatches.", n_received, n_sent,
             n_errors);
    if (n_errors == 0) begin
      $display("PASS thumb_store_immediate_unit");
    end else begin
      $display("FAIL thumb_store_immediate_unit");
    end
    $finish;
  end

endmodule
